[rtl/bsa_pkg.sv]
// Package: item types and operation codes for the bit-slice ALU register file.
package bsa_pkg;

   // Operand pair codes (R,S)
   typedef enum logic [2:0] {
      SRC_AQ = 3'd0,
      SRC_AB = 3'd1,
      SRC_ZQ = 3'd2,
      SRC_ZB = 3'd3,
      SRC_ZA = 3'd4,
      SRC_DA = 3'd5,
      SRC_DQ = 3'd6,
      SRC_DZ = 3'd7
   } bsa_src_type;

   // ALU function codes
   typedef enum logic [2:0] {
      FN_ADD   = 3'd0,
      FN_SUBR  = 3'd1,
      FN_SUBS  = 3'd2,
      FN_OR    = 3'd3,
      FN_AND   = 3'd4,
      FN_NOTRS = 3'd5,
      FN_EXOR  = 3'd6,
      FN_EXNOR = 3'd7
   } bsa_fn_type;

   // Destination codes
   typedef enum logic [2:0] {
      DST_QREG  = 3'd0,
      DST_NOP   = 3'd1,
      DST_RAMA  = 3'd2,
      DST_RAMF  = 3'd3,
      DST_RAMQD = 3'd4,
      DST_RAMD  = 3'd5,
      DST_RAMQU = 3'd6,
      DST_RAMU  = 3'd7
   } bsa_dst_type;

   localparam int unsigned WordWidth = 4;
   localparam int unsigned AddrWidth = 4;
   localparam int unsigned Depth     = 16;

   // One microinstruction
   typedef struct packed {
      logic [3:0] addr_a;
      logic [3:0] addr_b;
      logic [2:0] source_select;
      logic [2:0] action;
      logic [2:0] destination_select;
      logic [3:0] data_in;
      logic       carry_in;
      logic       output_enable;
      logic       ram_shift_in;
      logic       q_shift_in;
   } bsa_req_type;

   // One result
   typedef struct packed {
      logic [3:0] y_out;
      logic       sign_bit;
      logic       zero_flag;
      logic       carry_out;
      logic       overflow;
      logic       propagate_n;
      logic       generate_n;
      logic       ram_shift_out;
      logic       q_shift_out;
   } bsa_rsp_type;

endpackage

[rtl/bsa_chan_if.sv]
// Interfaces: valid/ready channels for microinstructions and results.
interface bsa_req_if;
   import bsa_pkg::*;
   logic        valid;
   logic        ready;
   bsa_req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bsa_rsp_if;
   import bsa_pkg::*;
   logic        valid;
   logic        ready;
   bsa_rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/bit_slice_alu_register_file.sv]
// Top level: four-bit slice with a sixteen-word register file, Q register and ALU.
//
// Usage:
//   req_chan carries one microinstruction per item (addresses, source, function,
//   destination, D, carry in, output enable, shift-in bits). rsp_chan returns
//   exactly one result item per microinstruction, in order: Y, sign, zero,
//   carry, overflow, lookahead P/G and the two shift-out bits.
//   Pipeline: an accepted item is registered into the execute stage, and its
//   result into the output register. The register file is a 16x4 memory with two
//   registered read ports; the acceptance edge reads A and B, the execute stage
//   computes F, and the edge on which it advances writes back word B and Q and loads the
//   result. A write that lands on a word the next item is reading
//   is forwarded, so items issue back to back at one per cycle.
//   Throughput: one item per cycle while results are taken, set by the single
//   read-modify-write pass through the register file.
//   Reset: synchronous, active high. All sixteen words and Q read as zero
//   afterward (per-word valid bits, no clearing pass); no result is pending.
//   Stall: the result sits in an output register; while rsp_chan.ready is low
//   one more item may be accepted and held in the execute stage, then
//   req_chan.ready drops until the result is taken.
module bit_slice_alu_register_file (
   input  logic       clock,
   input  logic       reset,
   bsa_req_if.sink    req_chan,
   bsa_rsp_if.source  rsp_chan
);
   import bsa_pkg::*;

   // Register file memory and per-word valid bits
   logic [WordWidth-1:0] mem [Depth];
   logic [Depth-1:0]     vld_ff, vld_in;

   // Execute stage
   logic                 s1_valid_ff, s1_valid_in;
   bsa_req_type          s1_req_ff;
   logic [WordWidth-1:0] rd_a_ff, rd_b_ff;
   logic                 rd_a_vld_ff, rd_b_vld_ff;
   logic                 byp_a_ff, byp_b_ff;
   logic [WordWidth-1:0] byp_data_ff;
   logic [WordWidth-1:0] q_ff, q_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   bsa_rsp_type rsp_data_ff;

   logic accept, advance;
   logic wr_en;
   logic [WordWidth-1:0] wr_data;

   logic [WordWidth-1:0] av, bv, r, s, rr, ss, f, p, g, y;
   logic [WordWidth:0]   sum, sum_nc;
   logic [WordWidth-1:0] sum3;
   logic c4, ovr, pn, gn, rso, qso, allp, anyg, x1, x2;
   bsa_rsp_type rsp_next;

   // Handshake: execute stage moves on when the output register frees up
   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Operand fetch with forwarding of the write in flight
   assign av = byp_a_ff ? byp_data_ff : (rd_a_vld_ff ? rd_a_ff : '0);
   assign bv = byp_b_ff ? byp_data_ff : (rd_b_vld_ff ? rd_b_ff : '0);

   // Source select
   always_comb begin
      case (s1_req_ff.source_select)
         SRC_AQ:  begin r = av; s = q_ff; end
         SRC_AB:  begin r = av; s = bv; end
         SRC_ZQ:  begin r = '0; s = q_ff; end
         SRC_ZB:  begin r = '0; s = bv; end
         SRC_ZA:  begin r = '0; s = av; end
         SRC_DA:  begin r = s1_req_ff.data_in; s = av; end
         SRC_DQ:  begin r = s1_req_ff.data_in; s = q_ff; end
         default: begin r = s1_req_ff.data_in; s = '0; end
      endcase
   end

   // ALU and flags
   always_comb begin
      rr = r;
      ss = s;
      if (s1_req_ff.action == FN_SUBR || s1_req_ff.action == FN_NOTRS ||
          s1_req_ff.action == FN_EXOR) begin
         rr = ~r;
      end
      if (s1_req_ff.action == FN_SUBS) begin
         ss = ~s;
      end
      sum    = {1'b0, rr} + {1'b0, ss} + {{WordWidth{1'b0}}, s1_req_ff.carry_in};
      sum_nc = {1'b0, rr} + {1'b0, ss};
      sum3   = {1'b0, rr[2:0]} + {1'b0, ss[2:0]} + {3'b000, s1_req_ff.carry_in};
      p      = rr | ss;
      g      = rr & ss;
      allp   = &p;
      anyg   = |g;
      x1 = !p[2] || (!g[2] && !p[1]) || (!g[2] && !g[1] && !p[0]) ||
           (!g[2] && !g[1] && !g[0] && s1_req_ff.carry_in);
      x2 = !p[3] || (!g[3] && !p[2]) || (!g[3] && !g[2] && !p[1]) ||
           (!g[3] && !g[2] && !g[1] && !p[0]) ||
           (!g[3] && !g[2] && !g[1] && !g[0] && s1_req_ff.carry_in);
      case (s1_req_ff.action)
         FN_ADD, FN_SUBR, FN_SUBS: begin
            f   = sum[WordWidth-1:0];
            c4  = sum[WordWidth];
            ovr = sum3[3] ^ sum[WordWidth];
            pn  = !allp;
            gn  = !sum_nc[WordWidth];
         end
         FN_OR: begin
            f   = r | s;
            pn  = 1'b0;
            gn  = allp;
            c4  = !allp || s1_req_ff.carry_in;
            ovr = c4;
         end
         FN_AND, FN_NOTRS: begin
            f   = (s1_req_ff.action == FN_AND) ? (r & s) : (~r & s);
            pn  = 1'b0;
            gn  = !anyg;
            c4  = anyg || s1_req_ff.carry_in;
            ovr = c4;
         end
         default: begin
            f   = (s1_req_ff.action == FN_EXOR) ? (r ^ s) : ~(r ^ s);
            pn  = anyg;
            gn  = g[3] || (p[3] && g[2]) || (p[3] && p[2] && g[1]) || allp;
            c4  = !(g[3] || (p[3] && g[2]) || (p[3] && p[2] && g[1]) ||
                    (allp && (g[0] || !s1_req_ff.carry_in)));
            ovr = x1 ^ x2;
         end
      endcase
   end

   // Destination: write-back word, Q update, Y and shift-outs
   always_comb begin
      wr_en   = 1'b1;
      wr_data = f;
      q_in    = q_ff;
      y       = f;
      rso     = 1'b0;
      qso     = 1'b0;
      case (s1_req_ff.destination_select)
         DST_QREG: begin
            wr_en = 1'b0;
            q_in  = f;
         end
         DST_NOP: begin
            wr_en = 1'b0;
         end
         DST_RAMA: begin
            y = av;
         end
         DST_RAMF: begin
            wr_data = f;
         end
         DST_RAMQD, DST_RAMD: begin
            wr_data = {s1_req_ff.ram_shift_in, f[3:1]};
            rso     = f[0];
            qso     = q_ff[0];
            if (s1_req_ff.destination_select == DST_RAMQD) begin
               q_in = {s1_req_ff.q_shift_in, q_ff[3:1]};
            end
         end
         default: begin
            wr_data = {f[2:0], s1_req_ff.ram_shift_in};
            rso     = f[3];
            qso     = q_ff[3];
            if (s1_req_ff.destination_select == DST_RAMQU) begin
               q_in = {q_ff[2:0], s1_req_ff.q_shift_in};
            end
         end
      endcase
      rsp_next.y_out         = s1_req_ff.output_enable ? y : '0;
      rsp_next.sign_bit      = f[3];
      rsp_next.zero_flag     = (f == '0);
      rsp_next.carry_out     = c4;
      rsp_next.overflow      = ovr;
      rsp_next.propagate_n   = pn;
      rsp_next.generate_n    = gn;
      rsp_next.ram_shift_out = rso;
      rsp_next.q_shift_out   = qso;
   end

   // Control next state
   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      vld_in       = vld_ff;
      if (advance && wr_en) begin
         vld_in[s1_req_ff.addr_b] = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
         q_ff         <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
         if (advance) begin
            q_ff <= q_in;
         end
      end
   end

   // Memory write port
   always_ff @(posedge clock) begin
      if (advance && wr_en) begin
         mem[s1_req_ff.addr_b] <= wr_data;
      end
   end

   // Memory read ports and forwarding capture at acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff   <= req_chan.data;
         rd_a_ff     <= mem[req_chan.data.addr_a];
         rd_b_ff     <= mem[req_chan.data.addr_b];
         rd_a_vld_ff <= vld_ff[req_chan.data.addr_a];
         rd_b_vld_ff <= vld_ff[req_chan.data.addr_b];
         byp_a_ff    <= advance && wr_en && (req_chan.data.addr_a == s1_req_ff.addr_b);
         byp_b_ff    <= advance && wr_en && (req_chan.data.addr_b == s1_req_ff.addr_b);
         byp_data_ff <= wr_data;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // An item is never taken while the execute stage is blocked
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(accept && s1_valid_ff && !advance))
      else $error("item accepted over a stalled execute stage");

   // Word valid bits only ever get set between resets
   a_vld_grow: assert property (@(posedge clock) disable iff (reset)
      ##1 ((vld_ff & $past(vld_ff)) == $past(vld_ff)))
      else $error("register file valid bit cleared outside reset");

   // Q holds while the execute stage does not advance
   a_q_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(q_ff))
      else $error("Q changed without an executed item");

   // A same-word write during acceptance is forwarded
   a_fwd: assert property (@(posedge clock) disable iff (reset)
      (accept && advance && wr_en && (req_chan.data.addr_b == s1_req_ff.addr_b))
      |=> byp_b_ff)
      else $error("write to the word being read was not forwarded");

   // Result register fills only from an executed item
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an item in execute");

endmodule

[tb/bit_slice_alu_register_file_checker.sv]
// Checker: watches both channels, predicts every result of the slice and compares.
module bit_slice_alu_register_file_checker (
   input  logic        clock,
   input  logic        reset,
   bsa_req_if          req_mon,
   bsa_rsp_if          rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);
   import bsa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the slice state
   logic [3:0]  slice_words [Depth];
   logic [3:0]  q_word;
   bsa_rsp_type expected_rsp [$];

   // Execute one microinstruction on the shadow state and return its result
   function automatic bsa_rsp_type slice_execute(input bsa_req_type mi);
      logic [3:0]  av, bv, qv, r, s, rr, ss, f, p, g, y;
      logic [4:0]  sum, raw;
      logic [3:0]  low3;
      logic        cin, c4, c3, ovr, pn, gn, allp, anyg, x1, x2, rso, qso;
      bsa_fn_type  fn;
      bsa_dst_type dst;
      bsa_rsp_type res;
      av  = slice_words[mi.addr_a];
      bv  = slice_words[mi.addr_b];
      qv  = q_word;
      cin = mi.carry_in;
      fn  = bsa_fn_type'(mi.action);
      dst = bsa_dst_type'(mi.destination_select);

      // Operand pair
      case (bsa_src_type'(mi.source_select))
         SRC_AQ: begin r = av; s = qv; end
         SRC_AB: begin r = av; s = bv; end
         SRC_ZQ: begin r = 4'd0; s = qv; end
         SRC_ZB: begin r = 4'd0; s = bv; end
         SRC_ZA: begin r = 4'd0; s = av; end
         SRC_DA: begin r = mi.data_in; s = av; end
         SRC_DQ: begin r = mi.data_in; s = qv; end
         default: begin r = mi.data_in; s = 4'd0; end
      endcase

      // ALU
      case (fn)
         FN_ADD, FN_SUBR, FN_SUBS: begin
            rr   = (fn == FN_SUBR) ? ~r : r;
            ss   = (fn == FN_SUBS) ? ~s : s;
            sum  = {1'b0, rr} + {1'b0, ss} + {4'd0, cin};
            f    = sum[3:0];
            c4   = sum[4];
            low3 = {1'b0, rr[2:0]} + {1'b0, ss[2:0]} + {3'd0, cin};
            c3   = low3[3];
            ovr  = c3 ^ c4;
            raw  = {1'b0, rr} + {1'b0, ss};
            pn   = ~&(rr | ss);
            gn   = ~raw[4];
         end
         default: begin
            // logic functions: flags come from P/G, R inverted for notR-and-S and xor
            rr   = (fn == FN_NOTRS || fn == FN_EXOR) ? ~r : r;
            p    = rr | s;
            g    = rr & s;
            allp = &p;
            anyg = |g;
            case (fn)
               FN_OR: begin
                  f = r | s;
                  pn = 1'b0; gn = allp; c4 = ~allp | cin; ovr = c4;
               end
               FN_AND, FN_NOTRS: begin
                  f = (fn == FN_AND) ? (r & s) : (~r & s);
                  pn = 1'b0; gn = ~anyg; c4 = anyg | cin; ovr = c4;
               end
               default: begin
                  f  = (fn == FN_EXOR) ? (r ^ s) : ~(r ^ s);
                  pn = anyg;
                  gn = g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1]) | allp;
                  c4 = ~(g[3] | (p[3] & g[2]) | (p[3] & p[2] & g[1])
                         | (allp & (g[0] | ~cin)));
                  x1 = ~p[2] | (~g[2] & ~p[1]) | (~g[2] & ~g[1] & ~p[0])
                       | (~g[2] & ~g[1] & ~g[0] & cin);
                  x2 = ~p[3] | (~g[3] & ~p[2]) | (~g[3] & ~g[2] & ~p[1])
                       | (~g[3] & ~g[2] & ~g[1] & ~p[0])
                       | (~g[3] & ~g[2] & ~g[1] & ~g[0] & cin);
                  ovr = x1 ^ x2;
               end
            endcase
         end
      endcase

      // Write-back; all reads above used the old state
      y   = f;
      rso = 1'b0;
      qso = 1'b0;
      case (dst)
         DST_QREG: q_word = f;
         DST_NOP: y = f;
         DST_RAMA: begin
            slice_words[mi.addr_b] = f;
            y = av;
         end
         DST_RAMF: slice_words[mi.addr_b] = f;
         DST_RAMQD, DST_RAMD: begin
            slice_words[mi.addr_b] = {mi.ram_shift_in, f[3:1]};
            rso = f[0];
            qso = qv[0];
            if (dst == DST_RAMQD) q_word = {mi.q_shift_in, qv[3:1]};
         end
         default: begin
            slice_words[mi.addr_b] = {f[2:0], mi.ram_shift_in};
            rso = f[3];
            qso = qv[3];
            if (dst == DST_RAMQU) q_word = {qv[2:0], mi.q_shift_in};
         end
      endcase

      res.y_out         = mi.output_enable ? y : 4'd0;
      res.sign_bit      = f[3];
      res.zero_flag     = (f == 4'd0);
      res.carry_out     = c4;
      res.overflow      = ovr;
      res.propagate_n   = pn;
      res.generate_n    = gn;
      res.ram_shift_out = rso;
      res.q_shift_out   = qso;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [3:0] want,
                                input logic [3:0] got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Results are checked before the new item is queued: a result never
   // belongs to an item accepted at the same edge
   always @(posedge clock) begin
      bsa_rsp_type want, got;
      if (reset) begin
         for (int i = 0; i < Depth; i++) slice_words[i] = 4'd0;
         q_word = 4'd0;
         expected_rsp.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (expected_rsp.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, actual %h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = expected_rsp.pop_front();
               compare_field("y_out", want.y_out, got.y_out);
               compare_field("sign_bit", 4'(want.sign_bit), 4'(got.sign_bit));
               compare_field("zero_flag", 4'(want.zero_flag), 4'(got.zero_flag));
               compare_field("carry_out", 4'(want.carry_out), 4'(got.carry_out));
               compare_field("overflow", 4'(want.overflow), 4'(got.overflow));
               compare_field("propagate_n", 4'(want.propagate_n), 4'(got.propagate_n));
               compare_field("generate_n", 4'(want.generate_n), 4'(got.generate_n));
               compare_field("ram_shift_out", 4'(want.ram_shift_out),
                             4'(got.ram_shift_out));
               compare_field("q_shift_out", 4'(want.q_shift_out), 4'(got.q_shift_out));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rsp.push_back(slice_execute(req_mon.data));
      end
      pending_count = expected_rsp.size();
   end

endmodule

[tb/bit_slice_alu_register_file_test.sv]
// Testbench top: clock, reset, microinstruction stimulus, result stalls and verdict.
module bit_slice_alu_register_file_test;
   import bsa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomItems = 800;
   localparam int unsigned IdleLimit   = 2000;

   logic        clock;
   logic        reset;
   logic        steady;
   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned idle_cycles;

   bsa_req_if req_chan ();
   bsa_rsp_if rsp_chan ();

   bit_slice_alu_register_file u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bit_slice_alu_register_file_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic bsa_req_type make_item(
      input logic [3:0] a, input logic [3:0] b, input bsa_src_type src,
      input bsa_fn_type fn, input bsa_dst_type dst, input logic [3:0] d,
      input logic cin, input logic oe, input logic rin, input logic qin);
      bsa_req_type mi;
      mi.addr_a             = a;
      mi.addr_b             = b;
      mi.source_select      = src;
      mi.action             = fn;
      mi.destination_select = dst;
      mi.data_in            = d;
      mi.carry_in           = cin;
      mi.output_enable      = oe;
      mi.ram_shift_in       = rin;
      mi.q_shift_in         = qin;
      return mi;
   endfunction

   // Send one item after a random gap; valid stays high across back-to-back items
   task automatic send_item(input bsa_req_type mi);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.data  <= mi;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   // Hold off until every outstanding result has come back
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Result side: random stall per item
   initial begin
      int unsigned gap;
      forever begin
         gap = steady ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("[bit_slice_alu_register_file] ERROR");
         $finish;
      end
   end

   initial begin
      bsa_req_type mi;
      logic [31:0] word;
      reset          = 1'b1;
      steady         = 1'b0;
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Seed a few words and Q with known values
      send_item(make_item(4'd0, 4'd15, SRC_DZ, FN_ADD, DST_RAMF, 4'd15, 1'b0, 1'b1, 1'b0, 1'b0));
      send_item(make_item(4'd0, 4'd5, SRC_DZ, FN_ADD, DST_RAMF, 4'd10, 1'b0, 1'b1, 1'b0, 1'b0));
      send_item(make_item(4'd0, 4'd0, SRC_DZ, FN_ADD, DST_QREG, 4'd5, 1'b0, 1'b1, 1'b0, 1'b0));

      // Every ALU function, logic flags included
      for (int k = 0; k < 8; k++)
         send_item(make_item(4'd15, 4'd5, SRC_AB, bsa_fn_type'(k[2:0]), DST_NOP, 4'd0,
                             k[0], 1'b1, 1'b0, 1'b0));

      // Largest sum with carry in
      send_item(make_item(4'd15, 4'd15, SRC_AB, FN_ADD, DST_NOP, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0));

      // Every source and destination, shifts with and without a Q write
      for (int k = 0; k < 8; k++)
         send_item(make_item(4'd15, 4'(k), bsa_src_type'(k[2:0]),
                             bsa_fn_type'(3'(k + 3)), bsa_dst_type'(k[2:0]),
                             4'(2 * k + 1), k[0], k != 3, k[1], ~k[0]));

      // Same word on A and B: Y shows the old word, then a read right after the write
      send_item(make_item(4'd5, 4'd5, SRC_AB, FN_ADD, DST_RAMA, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_item(make_item(4'd5, 4'd5, SRC_AB, FN_SUBS, DST_RAMA, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0));
      send_item(make_item(4'd15, 4'd15, SRC_DA, FN_EXNOR, DST_RAMU, 4'd0, 1'b0, 1'b1, 1'b1,
                          1'b1));
      send_item(make_item(4'd0, 4'd0, SRC_ZQ, FN_SUBR, DST_RAMQD, 4'd0, 1'b0, 1'b0, 1'b1,
                          1'b1));
      drain_results();

      // Random microinstructions; some use few addresses to force reuse
      for (int unsigned k = 0; k < RandomItems; k++) begin
         steady = (k >= 150 && k < 250) || (k >= 600 && k < 680);
         word = $urandom;
         mi = word[$bits(bsa_req_type)-1:0];
         mi.output_enable = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) begin
            mi.addr_a = 4'($urandom_range(0, 3));
            mi.addr_b = 4'($urandom_range(0, 3));
         end
         send_item(mi);
         if (k == RandomItems / 2) drain_results();
      end
      steady = 1'b0;
      req_chan.valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("[bit_slice_alu_register_file] OK");
      else
         $display("[bit_slice_alu_register_file] ERROR");
      $finish;
   end

endmodule
